/* rtl/ncd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ncd_pkg;

   localparam int MAX_CENTERS = 64;
   localparam int COORD_BITS  = 16;
   localparam int SLOT_BITS   = $clog2(MAX_CENTERS);
   localparam int CNT_BITS    = 7;
   localparam int FACTOR_BITS = 16;
   localparam int FACTOR_FRAC = 12;
   localparam int DIFF_BITS   = COORD_BITS + 1;
   localparam int SQ_BITS     = 2 * COORD_BITS;
   localparam int DIST_BITS   = SQ_BITS + 1;
   localparam int PROD_BITS   = DIFF_BITS + FACTOR_BITS;
   localparam int OUT_BITS    = 21;
   localparam int IN_DATA_BITS  = 40;
   localparam int OUT_DATA_BITS = 48;

   localparam logic REG_NUM_CENTERS = 1'b0;
   localparam logic REG_PULL_FACTOR = 1'b1;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_NODE  = 1'b1;

   typedef struct packed {
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] x;
   } pt_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SEARCH = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_DISP   = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

endpackage
`default_nettype wire

/* rtl/ncd_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module ncd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/ncd_dist.sv */
`timescale 1ns / 1ps
`default_nettype none
// Two-stage squared-distance unit: axis differences, then their squares.
// One candidate centre enters per cycle; the centre travels alongside.
module ncd_dist (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             in_valid,
   input  wire ncd_pkg::pt_type                  center,
   input  wire ncd_pkg::pt_type                  query,
   output      logic                             out_valid,
   output      ncd_pkg::pt_type                  out_center,
   output      logic [ncd_pkg::SQ_BITS-1:0]      sq_x,
   output      logic [ncd_pkg::SQ_BITS-1:0]      sq_y
);

   logic                                 diff_valid_ff;
   logic signed [ncd_pkg::DIFF_BITS-1:0] dx_ff, dx_in;
   logic signed [ncd_pkg::DIFF_BITS-1:0] dy_ff, dy_in;
   ncd_pkg::pt_type                      diff_center_ff;
   logic                                 sq_valid_ff;
   logic [ncd_pkg::SQ_BITS-1:0]          sq_x_ff, sq_y_ff;
   ncd_pkg::pt_type                      sq_center_ff;
   logic signed [2*ncd_pkg::DIFF_BITS-1:0] prod_x, prod_y;

   assign dx_in = $signed({1'b0, center.x}) - $signed({1'b0, query.x});
   assign dy_in = $signed({1'b0, center.y}) - $signed({1'b0, query.y});
   assign prod_x = dx_ff * dx_ff;
   assign prod_y = dy_ff * dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_valid_ff <= 1'b0;
         sq_valid_ff   <= 1'b0;
      end else begin
         diff_valid_ff <= in_valid;
         sq_valid_ff   <= diff_valid_ff;
      end
      dx_ff          <= dx_in;
      dy_ff          <= dy_in;
      diff_center_ff <= center;
      // A square of a 17-bit difference never exceeds 32 unsigned bits.
      sq_x_ff        <= prod_x[ncd_pkg::SQ_BITS-1:0];
      sq_y_ff        <= prod_y[ncd_pkg::SQ_BITS-1:0];
      sq_center_ff   <= diff_center_ff;
   end

   assign out_valid  = sq_valid_ff;
   assign out_center = sq_center_ff;
   assign sq_x       = sq_x_ff;
   assign sq_y       = sq_y_ff;

endmodule
`default_nettype wire

/* rtl/nearest_center_displace.sv */
`timescale 1ns / 1ps
`default_nettype none
// Nearest-centre search with displacement. A request with tuser 0 stores its point in the
// centre table at center_slot. A request with tuser 1 is a node point:
// the block reads the first num_centers centres (at most 64) from the table, one per cycle,
// through a shared squared-distance unit, keeps the nearest (lowest index on a tie), then
// returns centre + floor(pull_factor * (centre - node) / 4096) per axis. A node request
// is fed by the single table read port, one centre per cycle; the block accepts no
// other request meanwhile. A result waits in the output register while the next request
// is taken. With num_centers written as 0 the result is 0.
module nearest_center_displace (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // center_slot [5:0], point_x [21:6], point_y [37:22], zero padding above
   input  wire logic [ncd_pkg::IN_DATA_BITS-1:0]   req_tdata,
   // cmd
   input  wire logic                               req_tuser,
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // moved_x [20:0], moved_y [41:21], zero padding above
   output      logic [ncd_pkg::OUT_DATA_BITS-1:0]  rsp_tdata,
   input  wire logic                               csr_we,
   input  wire logic                               csr_index,
   input  wire logic [ncd_pkg::FACTOR_BITS-1:0]    csr_wdata
);

   localparam int CB = ncd_pkg::COORD_BITS;

   ncd_pkg::state_type                      state_ff, state_in;
   logic [ncd_pkg::CNT_BITS-1:0]            num_centers_ff;
   logic signed [ncd_pkg::FACTOR_BITS-1:0]  pull_factor_ff;
   logic [ncd_pkg::CNT_BITS-1:0]            count_ff, count_in;
   logic [ncd_pkg::CNT_BITS-1:0]            issue_cnt_ff, issue_cnt_in;
   logic [ncd_pkg::CNT_BITS-1:0]            cmp_cnt_ff, cmp_cnt_in;
   ncd_pkg::pt_type                         query_ff, query_in;
   ncd_pkg::pt_type                         best_ff, best_in;
   logic [ncd_pkg::DIST_BITS-1:0]           best_d_ff, best_d_in;
   logic                                    rd_valid_ff;
   logic signed [ncd_pkg::PROD_BITS-1:0]    prod_x_ff, prod_y_ff;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [ncd_pkg::OUT_BITS-1:0]            moved_x_ff, moved_y_ff;
   logic [ncd_pkg::OUT_BITS-1:0]            moved_x_in, moved_y_in;

   logic                                    req_fire;
   logic                                    issuing;
   ncd_pkg::pt_type                         req_point;
   logic [ncd_pkg::SLOT_BITS-1:0]           req_slot;
   ncd_pkg::pt_type                         ram_rdata;
   logic                                    sq_valid;
   ncd_pkg::pt_type                         sq_center;
   logic [ncd_pkg::SQ_BITS-1:0]             sq_x, sq_y;
   logic [ncd_pkg::DIST_BITS-1:0]           dist_sum;
   logic                                    take;
   logic                                    out_free;
   logic signed [ncd_pkg::DIFF_BITS-1:0]    diff_x, diff_y;
   logic signed [ncd_pkg::OUT_BITS:0]       sum_x, sum_y;

   assign req_tready = (state_ff == ncd_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_slot   = req_tdata[ncd_pkg::SLOT_BITS-1:0];
   assign req_point.x = req_tdata[ncd_pkg::SLOT_BITS +: CB];
   assign req_point.y = req_tdata[ncd_pkg::SLOT_BITS+CB +: CB];
   assign issuing    = (state_ff == ncd_pkg::ST_SEARCH);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   ncd_ram #(
      .WIDTH ($bits(ncd_pkg::pt_type)),
      .DEPTH (ncd_pkg::MAX_CENTERS)
   ) u_table (
      .clock   (clock),
      .wr_en   (req_fire && (req_tuser == ncd_pkg::CMD_WRITE)),
      .wr_addr (req_slot),
      .wr_data (req_point),
      .rd_en   (issuing),
      .rd_addr (issue_cnt_ff[ncd_pkg::SLOT_BITS-1:0]),
      .rd_data (ram_rdata)
   );

   ncd_dist u_dist (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (rd_valid_ff),
      .center     (ram_rdata),
      .query      (query_ff),
      .out_valid  (sq_valid),
      .out_center (sq_center),
      .sq_x       (sq_x),
      .sq_y       (sq_y)
   );

   assign dist_sum = {1'b0, sq_x} + {1'b0, sq_y};
   assign take = sq_valid && ((cmp_cnt_ff == '0) || (dist_sum < best_d_ff));

   assign diff_x = $signed({1'b0, best_ff.x}) - $signed({1'b0, query_ff.x});
   assign diff_y = $signed({1'b0, best_ff.y}) - $signed({1'b0, query_ff.y});

   // An arithmetic shift of the product is the floor of the division by 4096.
   assign sum_x = $signed({{(ncd_pkg::OUT_BITS+1-CB){1'b0}}, best_ff.x})
                + $signed({prod_x_ff[ncd_pkg::PROD_BITS-1],
                           prod_x_ff[ncd_pkg::PROD_BITS-1:ncd_pkg::FACTOR_FRAC]});
   assign sum_y = $signed({{(ncd_pkg::OUT_BITS+1-CB){1'b0}}, best_ff.y})
                + $signed({prod_y_ff[ncd_pkg::PROD_BITS-1],
                           prod_y_ff[ncd_pkg::PROD_BITS-1:ncd_pkg::FACTOR_FRAC]});

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_cnt_in = issue_cnt_ff;
      cmp_cnt_in   = cmp_cnt_ff;
      query_in     = query_ff;
      best_in      = best_ff;
      best_d_in    = best_d_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      moved_x_in   = moved_x_ff;
      moved_y_in   = moved_y_ff;

      if (take) begin
         best_in   = sq_center;
         best_d_in = dist_sum;
      end

      unique case (state_ff)
         ncd_pkg::ST_IDLE: begin
            if (req_fire && (req_tuser == ncd_pkg::CMD_NODE)) begin
               issue_cnt_in = '0;
               cmp_cnt_in   = '0;
               query_in     = req_point;
               if (num_centers_ff > ncd_pkg::CNT_BITS'(ncd_pkg::MAX_CENTERS)) begin
                  count_in = ncd_pkg::CNT_BITS'(ncd_pkg::MAX_CENTERS);
               end else begin
                  count_in = num_centers_ff;
               end
               if (num_centers_ff == '0) begin
                  // Zero centre and zero node give a zero result.
                  query_in = '0;
                  best_in  = '0;
                  state_in = ncd_pkg::ST_DISP;
               end else begin
                  state_in = ncd_pkg::ST_SEARCH;
               end
            end
         end
         ncd_pkg::ST_SEARCH: begin
            issue_cnt_in = issue_cnt_ff + 1'b1;
            if (issue_cnt_ff == count_ff - 1'b1) begin
               state_in = ncd_pkg::ST_DRAIN;
            end
         end
         ncd_pkg::ST_DRAIN: begin
            if (sq_valid && (cmp_cnt_ff == count_ff - 1'b1)) begin
               state_in = ncd_pkg::ST_DISP;
            end
         end
         ncd_pkg::ST_DISP: begin
            state_in = ncd_pkg::ST_EMIT;
         end
         ncd_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               moved_x_in   = sum_x[ncd_pkg::OUT_BITS-1:0];
               moved_y_in   = sum_y[ncd_pkg::OUT_BITS-1:0];
               state_in     = ncd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ncd_pkg::ST_IDLE;
         end
      endcase

      if (sq_valid) begin
         cmp_cnt_in = cmp_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ncd_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         rd_valid_ff    <= 1'b0;
         num_centers_ff <= ncd_pkg::CNT_BITS'(1);
         pull_factor_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= issuing;
         if (csr_we) begin
            unique case (csr_index)
               ncd_pkg::REG_NUM_CENTERS: num_centers_ff <= csr_wdata[ncd_pkg::CNT_BITS-1:0];
               ncd_pkg::REG_PULL_FACTOR: pull_factor_ff <= $signed(csr_wdata);
               default: ;
            endcase
         end
      end
      count_ff     <= count_in;
      issue_cnt_ff <= issue_cnt_in;
      cmp_cnt_ff   <= cmp_cnt_in;
      query_ff     <= query_in;
      best_ff      <= best_in;
      best_d_ff    <= best_d_in;
      prod_x_ff    <= diff_x * pull_factor_ff;
      prod_y_ff    <= diff_y * pull_factor_ff;
      moved_x_ff   <= moved_x_in;
      moved_y_ff   <= moved_y_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(ncd_pkg::OUT_DATA_BITS-2*ncd_pkg::OUT_BITS){1'b0}},
                        moved_y_ff, moved_x_ff};

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
   import ncd_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int SETTLE       = 80;
   localparam int TARGET_ITEMS = 400;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] my;
      logic signed [OUT_BITS-1:0] mx;
   } moved_t;

   class centre_scoreboard;
      logic [COORD_BITS-1:0]   cx [MAX_CENTERS];
      logic [COORD_BITS-1:0]   cy [MAX_CENTERS];
      logic [CNT_BITS-1:0]     count;
      logic signed [FACTOR_BITS-1:0] factor;
      moved_t                  moved_q [$];
      int                      errors;
      int                      loads;
      int                      nodes;
      int                      results;

      function new();
         count   = 1;
         factor  = 0;
         errors  = 0;
         loads   = 0;
         nodes   = 0;
         results = 0;
      endfunction

      function void write_reg(logic idx, logic [FACTOR_BITS-1:0] value);
         if (idx == REG_NUM_CENTERS)
            count = value[CNT_BITS-1:0];
         else
            factor = value;
      endfunction

      function logic signed [OUT_BITS-1:0] pulled(logic [COORD_BITS-1:0] c,
                                                   logic [COORD_BITS-1:0] p);
         longint diff;
         longint prod;
         diff = longint'(c) - longint'(p);
         prod = diff * longint'(factor);
         // Arithmetic shift of a signed value floors towards minus infinity.
         return OUT_BITS'(longint'(c) + (prod >>> FACTOR_FRAC));
      endfunction

      function moved_t nearest_displaced(logic [COORD_BITS-1:0] px,
                                         logic [COORD_BITS-1:0] py);
         longint best;
         longint d;
         longint dx;
         longint dy;
         int     n;
         int     win;
         moved_t m;
         n    = (count > MAX_CENTERS) ? MAX_CENTERS : int'(count);
         m    = '0;
         win  = 0;
         best = 0;
         for (int j = 0; j < n; j++) begin
            dx = longint'(cx[j]) - longint'(px);
            dy = longint'(cy[j]) - longint'(py);
            d  = dx * dx + dy * dy;
            if (j == 0 || d < best) begin
               best = d;
               win  = j;
            end
         end
         if (n > 0) begin
            m.mx = pulled(cx[win], px);
            m.my = pulled(cy[win], py);
         end
         return m;
      endfunction

      function void note_request(logic cmd, logic [IN_DATA_BITS-1:0] data);
         logic [SLOT_BITS-1:0]  slot;
         logic [COORD_BITS-1:0] px;
         logic [COORD_BITS-1:0] py;
         slot = data[SLOT_BITS-1:0];
         px   = data[SLOT_BITS +: COORD_BITS];
         py   = data[SLOT_BITS+COORD_BITS +: COORD_BITS];
         if (cmd == CMD_WRITE) begin
            cx[slot] = px;
            cy[slot] = py;
            loads++;
         end else begin
            moved_q.push_back(nearest_displaced(px, py));
            nodes++;
         end
      endfunction

      function void check_result(logic [OUT_DATA_BITS-1:0] data);
         moved_t                     want;
         logic signed [OUT_BITS-1:0] got_x;
         logic signed [OUT_BITS-1:0] got_y;
         got_x = data[OUT_BITS-1:0];
         got_y = data[2*OUT_BITS-1:OUT_BITS];
         results++;
         if (moved_q.size() == 0) begin
            $error("result x=%0d y=%0d arrived with nothing outstanding", got_x, got_y);
            errors++;
            return;
         end
         want = moved_q.pop_front();
         if (want.mx !== got_x) begin
            $error("moved_x: expected %0d, got %0d", want.mx, got_x);
            errors++;
         end
         if (want.my !== got_y) begin
            $error("moved_y: expected %0d, got %0d", want.my, got_y);
            errors++;
         end
      endfunction

      function int pending();
         return moved_q.size();
      endfunction

      function void final_check();
         if (moved_q.size() != 0) begin
            $error("%0d node results never arrived", moved_q.size());
            errors += moved_q.size();
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [IN_DATA_BITS-1:0]   req_tdata = '0;
   logic                      req_tuser = CMD_WRITE;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [OUT_DATA_BITS-1:0]  rsp_tdata;
   logic                      csr_we = 1'b0;
   logic                      csr_index = REG_NUM_CENTERS;
   logic [FACTOR_BITS-1:0]    csr_wdata = '0;

   centre_scoreboard sb;
   bit               loaded [MAX_CENTERS];
   bit               steady;
   bit               hold_request;
   int               hold_left;
   int               sent;
   int               phases;
   int               cycles;

   nearest_center_displace dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Both handshakes are sampled on values from before the edge, so no race with the drivers.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata);
      end
   end

   // Receiver: random back-pressure, with an occasional long hold-off on request.
   initial begin
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = 300;
            rsp_tready <= 1'b0;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 6)
               hold_left = $urandom_range(5, 30);
            rsp_tready <= (r >= 30);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 40);
   endfunction

   function automatic logic [COORD_BITS-1:0] coord();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return '0;
      else if (r == 1)
         return '1;
      else
         return COORD_BITS'($urandom);
   endfunction

   task automatic send_request(input logic cmd, input logic [SLOT_BITS-1:0] slot,
                               input logic [COORD_BITS-1:0] x,
                               input logic [COORD_BITS-1:0] y);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, y, x, slot};
      do @(posedge clock); while (!req_tready);
      if (cmd == CMD_WRITE)
         loaded[slot] = 1'b1;
      sent++;
   endtask

   task automatic load(input int slot, input logic [COORD_BITS-1:0] x,
                       input logic [COORD_BITS-1:0] y);
      send_request(CMD_WRITE, SLOT_BITS'(slot), x, y);
   endtask

   task automatic node(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
      send_request(CMD_NODE, SLOT_BITS'($urandom), x, y);
   endtask

   // A centre load gives no result, so the block may still be busy once the queue empties.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic program_regs(input logic [CNT_BITS-1:0] n,
                               input logic [FACTOR_BITS-1:0] f);
      logic [FACTOR_BITS-1:0] word;
      word = FACTOR_BITS'($urandom);
      word[CNT_BITS-1:0] = n;
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= REG_NUM_CENTERS;
      csr_wdata <= word;
      @(posedge clock);
      csr_index <= REG_PULL_FACTOR;
      csr_wdata <= f;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_reg(REG_NUM_CENTERS, word);
      sb.write_reg(REG_PULL_FACTOR, f);
      // Every centre that a node search can reach must hold a written value.
      for (int s = 0; s < MAX_CENTERS && s < int'(n); s++)
         if (!loaded[s])
            load(s, coord(), coord());
   endtask

   initial begin
      int n;
      int f;
      int r;
      sb           = new();
      steady       = 1'b0;
      hold_request = 1'b0;
      sent         = 0;
      phases       = 0;
      cycles       = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration: one centre searched and no pull.
      load(0, 16'h0000, 16'h0000);
      node(16'hFFFF, 16'hFFFF);
      drain();

      // Two identical centres give a distance tie, though either winner gives the same result.
      program_regs(4, 16'sh7FFF);
      load(1, 16'hFFFF, 16'hFFFF);
      load(2, 16'hFFFF, 16'hFFFF);
      load(3, 16'h8000, 16'h0000);
      node(16'h0000, 16'h0000);
      node(16'hFFFF, 16'hFFFF);
      node(16'hFFFF, 16'h0000);
      node(16'h8000, 16'h8000);
      node(16'h0000, 16'hFFFF);
      drain();

      program_regs(4, 16'h8000);
      node(16'h0000, 16'hFFFF);
      node(16'hFFFF, 16'h0000);
      node(16'h1234, 16'hABCD);
      drain();

      // A pull of -1 with small differences gives a small product that shifts to zero.
      program_regs(4, 16'hFFFF);
      node(16'h0001, 16'h0001);
      node(16'h0007, 16'h0003);
      drain();

      // With no centres searched the result is zero.
      program_regs(0, 16'h1000);
      node(16'hFFFF, 16'hFFFF);
      drain();

      while (sent < TARGET_ITEMS) begin
         r = $urandom_range(0, 9);
         if (phases == 1)
            n = 3;
         else if (r == 0)
            n = 0;
         else if (r == 1)
            n = MAX_CENTERS;
         else if (r == 2)
            n = $urandom_range(MAX_CENTERS + 1, 127);
         else
            n = $urandom_range(1, 8);
         r = $urandom_range(0, 5);
         f = (r == 0) ? 16'h8000 : (r == 1) ? 16'h7FFF : (r == 2) ? 0 : $urandom;
         program_regs(CNT_BITS'(n), FACTOR_BITS'(f));
         steady = ($urandom_range(0, 3) == 0);
         if (phases == 1) begin
            // Hold the output off long enough that the block backs up onto its input.
            steady       = 1'b1;
            hold_request = 1'b1;
            repeat (12) node(coord(), coord());
         end
         repeat ($urandom_range(20, 40)) begin
            if ($urandom_range(0, 4) == 0)
               load($urandom_range(0, MAX_CENTERS - 1), coord(), coord());
            else
               node(coord(), coord());
         end
         steady = 1'b0;
         phases++;
         drain();
      end

      sb.final_check();
      $display("Sent %0d requests (%0d centre loads, %0d nodes) across %0d random settings,",
               sent, sb.loads, sb.nodes, phases);
      $display("checked %0d results with zero, saturated and extreme centre counts and pulls.",
               sb.results);
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
